// File: src/stereo_air_width_output_stage_defines.svh
// Assertion macros shared by the stereo air/width output stage RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef STEREO_AIR_WIDTH_OUTPUT_STAGE_DEFINES_SVH
`define STEREO_AIR_WIDTH_OUTPUT_STAGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAWOS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SAWOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/sawos_pkg.sv
// Package for the stereo air/width output stage: widths, register map,
// gain types, control structs and gain clamp helpers. No dependencies.
`default_nettype none

package sawos_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEFF_FRAC_BITS = 15;
    // headroom above the Q sample format for mid + side times level
    localparam int DATA_GUARD      = 6;
    // lowpass state carries one bit above the Q sample format
    localparam int STATE_GUARD     = 1;
    // gains up to 4.0 in Q.COEFF_FRAC_BITS, signed
    localparam int G_W             = COEFF_FRAC_BITS + 4;
    localparam int ONE_Q           = 1 << COEFF_FRAC_BITS;

    localparam int AIR_GAIN_MIN    = -9830;
    localparam int AIR_GAIN_MAX    = 11469;

    localparam int AIR_COEFF_W     = 16;
    localparam int AIR_GAIN_W      = 15;
    localparam int WIDTH_GAIN_W    = 17;
    localparam int LEVEL_W         = 18;
    localparam int PAN_W           = 16;
    localparam int CFG_DATA_W      = 18;
    localparam int CFG_IDX_W       = 3;

    localparam int AIR_COEFF_RST   = 18775;
    localparam int AIR_GAIN_RST    = 0;
    localparam int WIDTH_GAIN_RST  = 32768;
    localparam int LEVEL_RST       = 32768;
    localparam int PAN_RST         = 23167;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AIR_COEFF    = 3'd0,
        REG_AIR_GAIN     = 3'd1,
        REG_WIDTH_GAIN   = 3'd2,
        REG_OUTPUT_LEVEL = 3'd3,
        REG_PAN_MODE     = 3'd4,
        REG_PAN_LEFT     = 3'd5,
        REG_PAN_RIGHT    = 3'd6,
        REG_MONO_MODE    = 3'd7
    } t_reg_idx;

    typedef logic signed [G_W-1:0] t_gain;

    typedef struct packed {
        t_gain coef;
        t_gain gain;
    } t_air_cfg;

    typedef struct packed {
        logic  mono;
        logic  pan;
        t_gain width;
        t_gain level;
        t_gain pan_l;
        t_gain pan_r;
    } t_mix_cfg;

    function automatic int data_w(input int sample_bits);
        return sample_bits + COEFF_FRAC_BITS + DATA_GUARD;
    endfunction

    function automatic int state_w(input int sample_bits);
        return sample_bits + COEFF_FRAC_BITS + STATE_GUARD;
    endfunction

    function automatic t_gain cap_gain(input logic [31:0] v, input logic [31:0] cap);
        return (v > cap) ? G_W'(cap) : G_W'(v);
    endfunction

    function automatic t_gain clamp_air(input logic signed [AIR_GAIN_W-1:0] v);
        t_gain res;
        if (v < AIR_GAIN_MIN) begin
            res = G_W'(AIR_GAIN_MIN);
        end else if (v > AIR_GAIN_MAX) begin
            res = G_W'(AIR_GAIN_MAX);
        end else begin
            res = G_W'(v);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: src/stereo_air_width_output_stage.sv
// Top level of the stereo air/width output stage: register file, sequencer,
// two channel lanes, merge stage and output register.
// Depends on sawos_pkg, sawos_lane, sawos_merge and the assertion macro header.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready) carries one stereo pair per
//    transaction, i_left_in and i_right_in, signed SAMPLE_BITS each.
//  - Output channel (o_out_valid / i_out_ready) carries the processed pair.
//  - Config port: i_cfg_we writes i_cfg_data to register i_cfg_idx; write
//    only while no transaction is in flight.
//  - Processing: the left and right lanes run in parallel, each doing two
//    fractional multiplies on a shared multiplier (lowpass update, then air
//    shelf). The merge stage then does two more rounds on its two
//    multipliers (width/pan, then level).
//  - Throughput: a new pair is taken only once the previous result is loaded
//    into the output register, after the four multiply rounds of that pair.
//  - o_in_ready is high whenever the sequencer is idle, even with a result
//    still waiting in the output register, so the next pair starts early.
//  - Receiver stall: a finished result waits in the merge stage until the
//    output register frees; no new pair is taken meanwhile.
//  - Reset (synchronous, active low): registers return to their defaults,
//    both lowpass states clear to zero, both channels go empty.
`default_nettype none

`include "stereo_air_width_output_stage_defines.svh"

module stereo_air_width_output_stage #(
    parameter int SAMPLE_BITS = sawos_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_left_in,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_right_in,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]           o_left_out,
    output logic signed [SAMPLE_BITS-1:0]           o_right_out,
    input  wire logic                               i_cfg_we,
    input  wire logic [sawos_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [sawos_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sawos_pkg::*;

    localparam int D_W = data_w(SAMPLE_BITS);

    typedef enum logic [3:0] {
        T_IDLE  = 4'b0001,
        T_LANE  = 4'b0010,
        T_MERGE = 4'b0100,
        T_LOAD  = 4'b1000
    } t_top_state;

    // configuration registers, raw as written; clamped on use
    logic [AIR_COEFF_W-1:0]         r_air_coeff;
    logic [AIR_GAIN_W-1:0]          r_air_gain;
    logic [WIDTH_GAIN_W-1:0]        r_width_gain;
    logic [LEVEL_W-1:0]             r_output_level;
    logic                           r_pan_mode;
    logic [PAN_W-1:0]               r_pan_left;
    logic [PAN_W-1:0]               r_pan_right;
    logic                           r_mono_mode;

    t_top_state                     r_state;
    t_top_state                     n_state;
    logic                           r_out_valid;
    logic signed [SAMPLE_BITS-1:0]  r_left_out;
    logic signed [SAMPLE_BITS-1:0]  r_right_out;

    t_air_cfg                       air_cfg;
    t_mix_cfg                       mix_cfg;
    logic                           in_acc;
    logic                           lane_l_start;
    logic                           lane_r_start;
    logic                           lane_l_done;
    logic                           lane_r_done;
    logic signed [D_W-1:0]          lane_l_y;
    logic signed [D_W-1:0]          lane_r_y;
    logic                           merge_start;
    logic                           merge_done;
    logic signed [SAMPLE_BITS-1:0]  merge_left;
    logic signed [SAMPLE_BITS-1:0]  merge_right;
    logic                           load;

    // ---------------- register file ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_air_coeff    <= AIR_COEFF_W'(AIR_COEFF_RST);
            r_air_gain     <= AIR_GAIN_W'(AIR_GAIN_RST);
            r_width_gain   <= WIDTH_GAIN_W'(WIDTH_GAIN_RST);
            r_output_level <= LEVEL_W'(LEVEL_RST);
            r_pan_mode     <= 1'b0;
            r_pan_left     <= PAN_W'(PAN_RST);
            r_pan_right    <= PAN_W'(PAN_RST);
            r_mono_mode    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_AIR_COEFF:    r_air_coeff    <= i_cfg_data[AIR_COEFF_W-1:0];
                REG_AIR_GAIN:     r_air_gain     <= i_cfg_data[AIR_GAIN_W-1:0];
                REG_WIDTH_GAIN:   r_width_gain   <= i_cfg_data[WIDTH_GAIN_W-1:0];
                REG_OUTPUT_LEVEL: r_output_level <= i_cfg_data[LEVEL_W-1:0];
                REG_PAN_MODE:     r_pan_mode     <= i_cfg_data[0];
                REG_PAN_LEFT:     r_pan_left     <= i_cfg_data[PAN_W-1:0];
                REG_PAN_RIGHT:    r_pan_right    <= i_cfg_data[PAN_W-1:0];
                REG_MONO_MODE:    r_mono_mode    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // gains clamped to their legal ranges: coef and pan to 1.0, width to
    // 2.0, level to 4.0, air gain to its signed window
    always_comb begin
        air_cfg.coef  = cap_gain(32'(r_air_coeff), 32'(ONE_Q));
        air_cfg.gain  = clamp_air($signed(r_air_gain));
        mix_cfg.mono  = r_mono_mode;
        mix_cfg.pan   = r_pan_mode;
        mix_cfg.width = cap_gain(32'(r_width_gain), 32'(2 * ONE_Q));
        mix_cfg.level = cap_gain(32'(r_output_level), 32'(4 * ONE_Q));
        mix_cfg.pan_l = cap_gain(32'(r_pan_left), 32'(ONE_Q));
        mix_cfg.pan_r = cap_gain(32'(r_pan_right), 32'(ONE_Q));
    end

    // ---------------- sequencer ----------------
    assign o_in_ready   = (r_state == T_IDLE);
    assign in_acc       = i_in_valid && o_in_ready;
    // lanes latch the samples straight off the ports at accept
    assign lane_l_start = in_acc;
    // in mono the right lane stays idle and keeps its lowpass state
    assign lane_r_start = in_acc && !r_mono_mode;
    assign merge_start  = (r_state == T_LANE) && lane_l_done;
    assign load         = (r_state == T_LOAD) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_IDLE:  if (in_acc) n_state = T_LANE;
            T_LANE:  if (lane_l_done) n_state = T_MERGE;
            T_MERGE: if (merge_done) n_state = T_LOAD;
            T_LOAD:  if (load) n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_left_out  <= merge_left;
            r_right_out <= merge_right;
        end
    end

    // ---------------- datapath ----------------
    sawos_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lane_l_start),
        .i_x     (i_left_in),
        .i_cfg   (air_cfg),
        .o_done  (lane_l_done),
        .o_y     (lane_l_y)
    );

    sawos_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lane_r_start),
        .i_x     (i_right_in),
        .i_cfg   (air_cfg),
        .o_done  (lane_r_done),
        .o_y     (lane_r_y)
    );

    sawos_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (merge_start),
        .i_l     (lane_l_y),
        .i_r     (lane_r_y),
        .i_cfg   (mix_cfg),
        .o_done  (merge_done),
        .o_left  (merge_left),
        .o_right (merge_right)
    );

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

    // ---------------- assertions ----------------
    `SAWOS_ASSERT_IMPL(a_lanes_in_step, i_clk, i_rst_n, lane_l_done, lane_r_done == !r_mono_mode, "right lane out of step with left lane")
    `SAWOS_ASSERT_IMPL(a_lane_done_state, i_clk, i_rst_n, lane_l_done, r_state == T_LANE, "lane finished outside lane phase")
    `SAWOS_ASSERT_IMPL(a_merge_done_state, i_clk, i_rst_n, merge_done, r_state == T_MERGE, "merge finished outside merge phase")
    `SAWOS_ASSERT_NEXT(a_load_fills_out, i_clk, i_rst_n, load, o_out_valid, "output register not filled after load")

endmodule

`default_nettype wire

// File: src/sawos_mul.sv
// Fractional multiplier: floor(a * g / 2^COEFF_FRAC_BITS), one narrow multiplier
// used twice on the halves of a. Depends on sawos_pkg.
`default_nettype none

module sawos_mul #(
    parameter int DATA_W = 45
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic signed [DATA_W-1:0]  i_a,
    input  wire sawos_pkg::t_gain          i_g,
    output logic                           o_done,
    output logic signed [DATA_W-1:0]       o_p
);
    import sawos_pkg::*;

    localparam int HALF = DATA_W / 2;
    localparam int M_W  = HALF + 1;
    localparam int PP_W = M_W + G_W;
    localparam int P_W  = DATA_W + G_W;

    logic signed [DATA_W-1:0] r_a;
    t_gain                    r_g;
    logic [2:0]               r_ph;
    logic signed [PP_W-1:0]   r_pp_hi;
    logic signed [PP_W-1:0]   r_pp_lo;
    logic signed [DATA_W-1:0] r_p;
    logic                     r_done;

    logic signed [M_W-1:0]    mul_a;
    logic signed [PP_W-1:0]   mul_p;
    logic signed [P_W-1:0]    sum_w;

    // high half (signed) first, then low half (zero extended)
    assign mul_a = r_ph[0] ? M_W'(r_a >>> HALF) : $signed({1'b0, r_a[HALF-1:0]});
    assign mul_p = mul_a * r_g;
    assign sum_w = (P_W'(r_pp_hi) <<< HALF) + P_W'(r_pp_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= '0;
            r_done <= 1'b0;
        end else begin
            r_ph   <= {r_ph[1:0], i_start};
            r_done <= r_ph[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_g <= i_g;
        end
        if (r_ph[0]) begin
            r_pp_hi <= mul_p;
        end
        if (r_ph[1]) begin
            r_pp_lo <= mul_p;
        end
        if (r_ph[2]) begin
            r_p <= DATA_W'(sum_w >>> COEFF_FRAC_BITS);
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

`default_nettype wire

// File: src/sawos_lane.sv
// One channel lane: one-pole lowpass state and air shelf on a single sample.
// Depends on sawos_pkg and sawos_mul.
`default_nettype none

module sawos_lane #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_rst_n,
    input  wire logic                                           i_start,
    input  wire logic signed [SAMPLE_BITS-1:0]                  i_x,
    input  wire sawos_pkg::t_air_cfg                            i_cfg,
    output logic                                                o_done,
    output logic signed [sawos_pkg::data_w(SAMPLE_BITS)-1:0]    o_y
);
    import sawos_pkg::*;

    localparam int D_W  = data_w(SAMPLE_BITS);
    localparam int ST_W = state_w(SAMPLE_BITS);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_MUL1 = 4'b0010,
        L_UPD  = 4'b0100,
        L_MUL2 = 4'b1000
    } t_lane_state;

    t_lane_state            r_st;
    t_lane_state            n_st;
    logic signed [ST_W-1:0] r_lp;
    logic signed [D_W-1:0]  r_xs;
    logic signed [D_W-1:0]  r_y;
    logic                   r_done;

    logic signed [D_W-1:0]  xs_in;
    logic signed [D_W-1:0]  lp_ext;
    logic signed [D_W-1:0]  sum_lp;
    logic signed [D_W-1:0]  mul_a;
    t_gain                  mul_g;
    logic                   mul_start;
    logic                   mul_done;
    logic signed [D_W-1:0]  mul_p;
    logic                   in_upd;
    logic                   lp_ovf;

    assign xs_in     = D_W'(i_x) <<< COEFF_FRAC_BITS;
    assign lp_ext    = D_W'(r_lp);
    assign in_upd    = (r_st == L_UPD);
    // first product: (xs - lp) * coef; second: (xs - s) * air gain
    assign mul_a     = in_upd ? (r_xs - lp_ext) : (xs_in - lp_ext);
    assign mul_g     = in_upd ? i_cfg.gain : i_cfg.coef;
    assign mul_start = i_start | in_upd;
    assign sum_lp    = lp_ext + mul_p;
    assign lp_ovf    = !((&sum_lp[D_W-1:ST_W-1]) || !(|sum_lp[D_W-1:ST_W-1]));

    sawos_mul #(
        .DATA_W (D_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_g     (mul_g),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            L_IDLE: if (i_start) n_st = L_MUL1;
            L_MUL1: if (mul_done) n_st = L_UPD;
            L_UPD:  n_st = L_MUL2;
            L_MUL2: if (mul_done) n_st = L_IDLE;
            default: n_st = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= L_IDLE;
            r_lp   <= '0;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= (r_st == L_MUL2) && mul_done;
            if ((r_st == L_MUL1) && mul_done) begin
                if (lp_ovf) begin
                    r_lp <= sum_lp[D_W-1] ? {1'b1, {(ST_W-1){1'b0}}}
                                          : {1'b0, {(ST_W-1){1'b1}}};
                end else begin
                    r_lp <= sum_lp[ST_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_xs <= xs_in;
        end
        if ((r_st == L_MUL2) && mul_done) begin
            r_y <= r_xs + mul_p;
        end
    end

    assign o_done = r_done;
    assign o_y    = r_y;

endmodule

`default_nettype wire

// File: src/sawos_merge.sv
// Merge stage: mid/side width, mono fold with pan, or mono pass, then output
// level and saturation. Two multiplier units, one per output side.
// Depends on sawos_pkg and sawos_mul.
`default_nettype none

module sawos_merge #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_rst_n,
    input  wire logic                                           i_start,
    input  wire logic signed [sawos_pkg::data_w(SAMPLE_BITS)-1:0] i_l,
    input  wire logic signed [sawos_pkg::data_w(SAMPLE_BITS)-1:0] i_r,
    input  wire sawos_pkg::t_mix_cfg                            i_cfg,
    output logic                                                o_done,
    output logic signed [SAMPLE_BITS-1:0]                       o_left,
    output logic signed [SAMPLE_BITS-1:0]                       o_right
);
    import sawos_pkg::*;

    localparam int D_W = data_w(SAMPLE_BITS);

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_S1   = 4'b0010,
        M_MID  = 4'b0100,
        M_S2   = 4'b1000
    } t_merge_state;

    t_merge_state                 r_st;
    t_merge_state                 n_st;
    logic signed [D_W-1:0]        r_mid;
    logic signed [D_W-1:0]        r_a_l;
    logic signed [D_W-1:0]        r_a_r;
    logic signed [SAMPLE_BITS-1:0] r_left;
    logic signed [SAMPLE_BITS-1:0] r_right;
    logic                         r_done;

    logic signed [D_W:0]          sum_lr;
    logic signed [D_W:0]          dif_lr;
    logic signed [D_W-1:0]        mid;
    logic signed [D_W-1:0]        dhalf;
    logic signed [D_W-1:0]        s1_a_l;
    t_gain                        s1_g_l;
    logic signed [D_W-1:0]        mul_a_l;
    logic signed [D_W-1:0]        mul_a_r;
    t_gain                        mul_g_l;
    t_gain                        mul_g_r;
    logic                         mul_start;
    logic                         done_l;
    logic                         done_r;
    logic                         both_done;
    logic signed [D_W-1:0]        p_l;
    logic signed [D_W-1:0]        p_r;
    logic                         in_s2;

    function automatic logic signed [SAMPLE_BITS-1:0] to_sample(
        input logic signed [D_W-1:0] v
    );
        logic signed [D_W-1:0]       sh;
        logic [D_W-SAMPLE_BITS:0]    hi_bits;
        logic signed [SAMPLE_BITS-1:0] res;
        sh      = v >>> COEFF_FRAC_BITS;
        hi_bits = sh[D_W-1:SAMPLE_BITS-1];
        if ((&hi_bits) || !(|hi_bits)) begin
            res = sh[SAMPLE_BITS-1:0];
        end else if (sh[D_W-1]) begin
            res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return res;
    endfunction

    assign sum_lr = (D_W+1)'(i_l) + (D_W+1)'(i_r);
    assign dif_lr = (D_W+1)'(i_l) - (D_W+1)'(i_r);
    assign mid    = D_W'(sum_lr >>> 1);
    assign dhalf  = D_W'(dif_lr >>> 1);

    // stage 1, left unit: mono passes l at unity, pan scales the fold,
    // width scales the half difference (side)
    always_comb begin
        if (i_cfg.mono) begin
            s1_a_l = i_l;
            s1_g_l = G_W'(ONE_Q);
        end else if (i_cfg.pan) begin
            s1_a_l = mid;
            s1_g_l = i_cfg.pan_l;
        end else begin
            s1_a_l = dhalf;
            s1_g_l = i_cfg.width;
        end
    end

    assign in_s2     = (r_st == M_MID);
    assign mul_start = i_start | in_s2;
    assign mul_a_l   = in_s2 ? r_a_l : s1_a_l;
    assign mul_g_l   = in_s2 ? i_cfg.level : s1_g_l;
    assign mul_a_r   = in_s2 ? r_a_r : mid;
    assign mul_g_r   = in_s2 ? i_cfg.level : i_cfg.pan_r;
    assign both_done = done_l & done_r;

    sawos_mul #(
        .DATA_W (D_W)
    ) u_mul_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a_l),
        .i_g     (mul_g_l),
        .o_done  (done_l),
        .o_p     (p_l)
    );

    sawos_mul #(
        .DATA_W (D_W)
    ) u_mul_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a_r),
        .i_g     (mul_g_r),
        .o_done  (done_r),
        .o_p     (p_r)
    );

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            M_IDLE: if (i_start) n_st = M_S1;
            M_S1:   if (both_done) n_st = M_MID;
            M_MID:  n_st = M_S2;
            M_S2:   if (both_done) n_st = M_IDLE;
            default: n_st = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= M_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= (r_st == M_S2) && both_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mid <= mid;
        end
        if ((r_st == M_S1) && both_done) begin
            if (i_cfg.mono || i_cfg.pan) begin
                r_a_l <= p_l;
                r_a_r <= p_r;
            end else begin
                r_a_l <= r_mid + p_l;
                r_a_r <= r_mid - p_l;
            end
        end
        if ((r_st == M_S2) && both_done) begin
            r_left  <= to_sample(p_l);
            r_right <= i_cfg.mono ? '0 : to_sample(p_r);
        end
    end

    assign o_done  = r_done;
    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

`default_nettype wire
